// ===== src/base64_vigenere_cipher_core_defines.svh =====
// Assertion macros shared by the cipher core.
`ifndef BASE64_VIGENERE_CIPHER_CORE_DEFINES_SVH
`define BASE64_VIGENERE_CIPHER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define B64VC_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define B64VC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define B64VC_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons)
`define B64VC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)
`endif

`endif

// ===== src/b64vc_pkg.sv =====
package b64vc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_KEY_LEN  = 2'd1;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd2;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd3;

  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned KEY_LEN_W = 5;
  localparam int unsigned KEY_LOW_W  = 60;
  localparam int unsigned KEY_HIGH_W = 36;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Control from the byte path to the key schedule for one transfer.
  typedef struct packed {
    logic advance;
    logic first;
    logic pad;
  } key_ctl_t;

endpackage

// ===== src/b64vc_map.sv =====
module b64vc_map (
  input  logic       mode,
  input  logic [5:0] digit,
  input  logic [7:0] char_in,
  output logic       pad,
  output logic [7:0] char_out
);

  logic       is_letter;
  logic [5:0] value;
  logic [5:0] shifted;

  assign pad = (char_in == b64vc_pkg::PAD_CHAR);

  always_comb begin
    is_letter = 1'b1;
    value     = 6'd0;
    if (char_in >= 8'h41 && char_in <= 8'h5A) begin
      value = 6'(char_in - 8'h41);
    end else if (char_in >= 8'h61 && char_in <= 8'h7A) begin
      value = 6'(char_in - 8'h47);
    end else if (char_in >= 8'h30 && char_in <= 8'h39) begin
      value = 6'(char_in + 8'h04);
    end else if (char_in == 8'h2B) begin
      value = 6'd62;
    end else if (char_in == 8'h2F) begin
      value = 6'd63;
    end else begin
      is_letter = 1'b0;
    end
  end

  // Six-bit arithmetic wraps modulo 64 on its own.
  assign shifted = mode ? (value - digit) : (value + digit);

  always_comb begin
    if (!is_letter) begin
      char_out = char_in;
    end else if (shifted < 6'd26) begin
      char_out = 8'h41 + {2'b00, shifted};
    end else if (shifted < 6'd52) begin
      char_out = 8'h47 + {2'b00, shifted};
    end else if (shifted < 6'd62) begin
      char_out = {2'b00, shifted} - 8'h04;
    end else if (shifted == 6'd62) begin
      char_out = 8'h2B;
    end else begin
      char_out = 8'h2F;
    end
  end

endmodule

// ===== src/b64vc_keysched.sv =====
module b64vc_keysched #(
  parameter int unsigned KEY_MAX = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [b64vc_pkg::KEY_LEN_W-1:0]       key_length,
  input  logic [b64vc_pkg::KEY_LOW_W-1:0]       key_digits_low,
  input  logic [b64vc_pkg::KEY_HIGH_W-1:0]      key_digits_high,
  input  b64vc_pkg::key_ctl_t                   ctl,
  output logic [b64vc_pkg::DIGIT_W-1:0]         digit
);

  localparam int unsigned PW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned LW = b64vc_pkg::KEY_LEN_W;
  localparam int unsigned DW = b64vc_pkg::DIGIT_W;
  localparam int unsigned ALL_W = b64vc_pkg::KEY_LOW_W + b64vc_pkg::KEY_HIGH_W;

  logic [PW-1:0]    key_pos_r;
  logic [PW-1:0]    key_pos_nxt;
  logic [LW-1:0]    eff_len;
  logic [PW-1:0]    cur_pos;
  logic [PW-1:0]    use_pos;
  logic [LW-1:0]    next_wide;
  logic [PW-1:0]    next_pos;
  logic [ALL_W-1:0] all_digits;

  always_comb begin
    if (key_length == '0) begin
      eff_len = LW'(1);
    end else if (key_length > LW'(KEY_MAX)) begin
      eff_len = LW'(KEY_MAX);
    end else begin
      eff_len = key_length;
    end
  end

  // A first byte restarts the key; a stale position past the length uses digit 0.
  assign cur_pos   = ctl.first ? '0 : key_pos_r;
  assign use_pos   = (LW'(cur_pos) >= eff_len) ? '0 : cur_pos;
  assign next_wide = LW'(use_pos) + LW'(1);
  assign next_pos  = (next_wide >= eff_len) ? '0 : PW'(next_wide);

  assign all_digits = {key_digits_high, key_digits_low};
  assign digit      = all_digits[DW * 32'(use_pos) +: DW];

  always_comb begin
    key_pos_nxt = key_pos_r;
    if (ctl.advance) begin
      key_pos_nxt = ctl.pad ? cur_pos : next_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r <= '0;
    end else begin
      key_pos_r <= key_pos_nxt;
    end
  end

endmodule

// ===== src/base64_vigenere_cipher_core.sv =====
// Vigenere cipher over the base64 alphabet, one byte per transfer. Bytes enter an
// input register and leave through an output register; a result waits in the input
// register while the output register is stalled. The core sustains one byte per
// cycle while out_ready stays high: the key position register is updated once per
// byte as the byte moves from the input register to the output register. '=' passes
// unchanged and keeps the key position. Other bytes outside the alphabet pass
// unchanged but use up a key digit. in_first restarts the key at digit 0. Write
// configuration only while no byte is in flight.
`include "base64_vigenere_cipher_core_defines.svh"

module base64_vigenere_cipher_core #(
  parameter int unsigned KEY_MAX = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [59:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char
);

  localparam int unsigned LW = b64vc_pkg::KEY_LEN_W;

  logic                                mode_r;
  logic [LW-1:0]                       key_length_r;
  logic [b64vc_pkg::KEY_LOW_W-1:0]     key_digits_low_r;
  logic [b64vc_pkg::KEY_HIGH_W-1:0]    key_digits_high_r;

  logic       a_valid_r;
  logic [7:0] a_char_r;
  logic       a_first_r;
  logic       out_valid_r;
  logic [7:0] out_char_r;

  logic                           a_advance;
  logic                           pad;
  logic [7:0]                     mapped;
  logic [b64vc_pkg::DIGIT_W-1:0]  digit;
  b64vc_pkg::key_ctl_t            key_ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r            <= 1'b0;
      key_length_r      <= LW'(1);
      key_digits_low_r  <= '0;
      key_digits_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        b64vc_pkg::CFG_MODE:     mode_r <= cfg_wdata[0];
        b64vc_pkg::CFG_KEY_LEN:  key_length_r <= cfg_wdata[LW-1:0];
        b64vc_pkg::CFG_KEY_LOW:  key_digits_low_r <= cfg_wdata;
        b64vc_pkg::CFG_KEY_HIGH: key_digits_high_r <= cfg_wdata[b64vc_pkg::KEY_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the output register is empty or drained.
  assign a_advance = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !a_valid_r || a_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_char_r  <= in_char;
      a_first_r <= in_first;
    end
  end

  assign key_ctl.advance = a_advance;
  assign key_ctl.first   = a_first_r;
  assign key_ctl.pad     = pad;

  b64vc_keysched #(
    .KEY_MAX (KEY_MAX)
  ) u_keysched (
    .clk             (clk),
    .rst_n           (rst_n),
    .key_length      (key_length_r),
    .key_digits_low  (key_digits_low_r),
    .key_digits_high (key_digits_high_r),
    .ctl             (key_ctl),
    .digit           (digit)
  );

  b64vc_map u_map (
    .mode     (mode_r),
    .digit    (digit),
    .char_in  (a_char_r),
    .pad      (pad),
    .char_out (mapped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      out_char_r <= mapped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;

  `B64VC_ASSERT_NEXT(a_move_fills_out, clk, rst_n, a_advance, out_valid)
  `B64VC_ASSERT_NEXT(pad_passes, clk, rst_n, a_advance && pad, out_char == b64vc_pkg::PAD_CHAR)
  `B64VC_ASSERT_IMPL(no_overrun, clk, rst_n, a_valid_r && out_valid_r && !out_ready, !in_ready)

endmodule
